[rtl/scp_pkg.sv]
// ----------------------------------------------------------------------------
// scp_pkg
// Types and constants shared by the controller shift port block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scp_pkg;

  localparam int SHIFT_LENGTH_DEFAULT = 24;
  localparam int INDEX_WIDTH          = 5;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_SET   = 2'd2;

  localparam logic [15:0] PORT_ONE_ADDR = 16'h4016;
  localparam logic [15:0] PORT_TWO_ADDR = 16'h4017;
  localparam logic [7:0]  OPEN_BUS_BITS = 8'h40;
  localparam logic [7:0]  STROBE_ON     = 8'h01;

  localparam int SIG_PORT_ONE   = 19;
  localparam int SIG_PORT_TWO   = 18;
  localparam int HIGH_PAD_SHIFT = 8;

  localparam logic [2:0] PAD_ONE   = 3'd1;
  localparam logic [2:0] PAD_TWO   = 3'd2;
  localparam logic [2:0] PAD_THREE = 3'd3;
  localparam logic [2:0] PAD_FOUR  = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [2:0]  controller_number;
    logic [7:0]  buttons;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       address_error;
  } result_t;

endpackage

[rtl/scp_core.sv]
// ----------------------------------------------------------------------------
// scp_core
// Port images, read indices and strobe; executes one item per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scp_core #(
  parameter int SHIFT_LENGTH = scp_pkg::SHIFT_LENGTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  scp_pkg::item_t   item,
  output logic             result_valid,
  output scp_pkg::result_t result
);
  import scp_pkg::*;

  localparam int IW = INDEX_WIDTH;
  localparam int BW = $clog2(SHIFT_LENGTH);

  logic [SHIFT_LENGTH-1:0] port_one_bits, port_one_bits_next;
  logic [SHIFT_LENGTH-1:0] port_two_bits, port_two_bits_next;
  logic [IW-1:0]           port_one_index, port_one_index_next;
  logic [IW-1:0]           port_two_index, port_two_index_next;
  logic [7:0]              strobe_value, strobe_value_next;

  logic                    strobed;
  logic [IW-1:0]           one_pos, two_pos;

  assign strobed = (strobe_value == STROBE_ON);
  assign one_pos = (32'(port_one_index) >= SHIFT_LENGTH) ? '0 : port_one_index;
  assign two_pos = (32'(port_two_index) >= SHIFT_LENGTH) ? '0 : port_two_index;

  always_comb begin
    port_one_bits_next  = port_one_bits;
    port_two_bits_next  = port_two_bits;
    port_one_index_next = port_one_index;
    port_two_index_next = port_two_index;
    strobe_value_next   = strobe_value;
    result_valid        = 1'b0;
    result              = '0;
    if (go) begin
      unique case (item.kind)
        KIND_READ: begin
          result_valid = 1'b1;
          if (item.address == PORT_ONE_ADDR) begin
            if (strobed) begin
              result.read_data = OPEN_BUS_BITS | {7'd0, port_one_bits[0]};
            end else begin
              result.read_data = OPEN_BUS_BITS | {7'd0, port_one_bits[one_pos[BW-1:0]]};
              port_one_index_next = one_pos + IW'(1);
            end
          end else if (item.address == PORT_TWO_ADDR) begin
            if (strobed) begin
              result.read_data = OPEN_BUS_BITS | {7'd0, port_two_bits[0]};
            end else begin
              result.read_data = OPEN_BUS_BITS | {7'd0, port_two_bits[two_pos[BW-1:0]]};
              port_two_index_next = two_pos + IW'(1);
            end
          end else begin
            result.address_error = 1'b1;
          end
        end
        KIND_WRITE: begin
          if (strobed && item.write_data == 8'd0) begin
            port_one_index_next = '0;
            port_two_index_next = '0;
          end
          strobe_value_next = item.write_data;
        end
        KIND_SET: begin
          unique case (item.controller_number)
            PAD_ONE: begin
              port_one_bits_next[7:0]          = item.buttons;
              port_one_bits_next[SIG_PORT_ONE] = 1'b1;
            end
            PAD_TWO: begin
              port_two_bits_next[7:0]          = item.buttons;
              port_two_bits_next[SIG_PORT_TWO] = 1'b1;
            end
            PAD_THREE: port_one_bits_next[HIGH_PAD_SHIFT +: 8] = item.buttons;
            PAD_FOUR:  port_two_bits_next[HIGH_PAD_SHIFT +: 8] = item.buttons;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_one_bits  <= '0;
      port_two_bits  <= '0;
      port_one_index <= '0;
      port_two_index <= '0;
      strobe_value   <= '0;
    end else begin
      port_one_bits  <= port_one_bits_next;
      port_two_bits  <= port_two_bits_next;
      port_one_index <= port_one_index_next;
      port_two_index <= port_two_index_next;
      strobe_value   <= strobe_value_next;
    end
  end

endmodule

[rtl/strobed_controller_shift_ports.sv]
// ----------------------------------------------------------------------------
// strobed_controller_shift_ports
// Two serial controller ports with a four-player adapter.
//
// Input channel item_valid / item_stall / item carries bus reads, bus writes
// and controller button loads. Output channel result_valid / result_stall /
// result carries one item for each bus read; writes and loads give none.
// An accepted item is held in an input register and executed against the
// port state once the skid register is empty; its result lands in the
// output register, or in the skid register if the output is stalled. One
// item per cycle is sustained while the output is not stalled. When the
// receiver stalls, one more result is parked in the skid register; item_stall
// rises only while that skid register is full and an item waits in the
// input register. Reset clears both port images, both read indices, the
// strobe and all valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module strobed_controller_shift_ports #(
  parameter int SHIFT_LENGTH = scp_pkg::SHIFT_LENGTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  scp_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output scp_pkg::result_t result
);
  import scp_pkg::*;

  logic    held_valid;
  item_t   held;
  logic    skid_valid;
  result_t skid;
  logic    go;
  logic    take;
  logic    new_valid;
  result_t new_result;

  assign item_stall = held_valid && skid_valid;
  assign go         = held_valid && !skid_valid;
  assign take       = result_valid && !result_stall;

  scp_core #(
    .SHIFT_LENGTH(SHIFT_LENGTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .go           (go),
    .item         (held),
    .result_valid (new_valid),
    .result       (new_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      held_valid <= 1'b1;
    end else if (go) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        result     <= skid;
        skid_valid <= 1'b0;
      end
    end else if (new_valid) begin
      if (!result_valid || take) begin
        result       <= new_result;
        result_valid <= 1'b1;
      end else begin
        skid       <= new_result;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

endmodule
